### hdl/mfde_pkg.sv
package mfde_pkg;

    // default store geometry
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 64;

    // command codes
    localparam logic [2:0] MODE_FILL    = 3'd0;
    localparam logic [2:0] MODE_OUTLINE = 3'd1;
    localparam logic [2:0] MODE_CURSOR  = 3'd2;
    localparam logic [2:0] MODE_CLEAR   = 3'd3;
    localparam logic [2:0] MODE_READ    = 3'd4;

    // configuration register indexes
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic push;
    } mfde_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_full;
    } mfde_stat_t;

endpackage

### hdl/mono_framebuffer_draw_engine.sv
// channel   | handshake          | payload
// ----------+--------------------+---------------------------------------------
// s_        | s_valid / s_ready  | s_mode, s_pos_x, s_pos_y, s_size_w, s_size_h
// m_        | m_valid / m_ready  | m_pixel_value, m_status
// cfg_      | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// one request at a time: accept, setup, a walk over the rows, a check that
// sees the walk end, drain, done (rows = clipped rectangle rows, cursor
// height, 1 for an in-range read, 0 otherwise); the row read-modify-write
// through the store's one write and one read port sets the pace.
// reset takes effect at once: each store row carries a valid bit that reset and
// the clear request drop, and a row that is not valid reads as all zeros.
// a finished result sits in the output register; the next request is taken
// while it waits, and only the push of the following result stalls on m_ready.
module mono_framebuffer_draw_engine #(
    parameter int MAX_WIDTH  = mfde_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mfde_pkg::MAX_HEIGHT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic [14:0]        s_size_w,
    input  logic [14:0]        s_size_h,

    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_pixel_value,
    output logic               m_status,

    // configuration writes
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_wdata
);
    import mfde_pkg::*;

    // command and status between sequencer and datapath
    mfde_cmd_t  cmd;
    mfde_stat_t stat;

    // sequencer: accept, setup, row walk, drain, result push
    mfde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: clipping, row masks, pixel store, result register
    mfde_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (s_mode),
        .pos_x         (s_pos_x),
        .pos_y         (s_pos_y),
        .size_w        (s_size_w),
        .size_h        (s_size_h),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_pixel_value (m_pixel_value),
        .m_status      (m_status)
    );

endmodule

### hdl/mfde_ram.sv
module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mfde_ctrl.sv
module mfde_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  m_ready,
    input  mfde_pkg::mfde_stat_t  stat,
    output mfde_pkg::mfde_cmd_t   cmd
);
    import mfde_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (stat.walk_done) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            // spare state after the last row write
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!stat.out_full || m_ready) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/mfde_dp.sv
module mfde_dp #(
    parameter int MAX_WIDTH  = mfde_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mfde_pkg::MAX_HEIGHT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mfde_pkg::mfde_cmd_t   cmd,
    output mfde_pkg::mfde_stat_t  stat,
    input  logic [2:0]            mode,
    input  logic signed [15:0]    pos_x,
    input  logic signed [15:0]    pos_y,
    input  logic [14:0]           size_w,
    input  logic [14:0]           size_h,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [8:0]            cfg_wdata,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic                  m_pixel_value,
    output logic                  m_status
);
    import mfde_pkg::*;

    localparam int         ColAw = $clog2(MAX_WIDTH);
    localparam int         RowAw = $clog2(MAX_HEIGHT);
    localparam logic [8:0] MaxW  = 9'(MAX_WIDTH);
    localparam logic [8:0] MaxH  = 9'(MAX_HEIGHT);
    localparam logic [8:0] Full  = 9'd256;

    function automatic logic [8:0] clamp_dim(input logic signed [17:0] v,
                                             input logic [8:0] hi);
        logic [8:0] r;
        if (v < 18'sd0) begin
            r = '0;
        end else if (v > $signed({9'b0, hi})) begin
            r = hi;
        end else begin
            r = v[8:0];
        end
        return r;
    endfunction

    function automatic logic in_dim(input logic signed [17:0] v,
                                    input logic [8:0] hi);
        return (v >= 18'sd0) && (v < $signed({9'b0, hi}));
    endfunction

    // command fields
    logic [2:0]          mode_reg;
    logic signed [15:0]  px_reg;
    logic signed [15:0]  py_reg;
    logic [14:0]         sw_reg;
    logic [14:0]         sh_reg;

    // screen registers
    logic [8:0] scr_w_reg;
    logic [6:0] scr_h_reg;
    logic [8:0] dim_w;
    logic [8:0] dim_h;

    // clipped bounds
    logic [8:0] x0_reg, x1_reg;
    logic [7:0] lcol_reg, rcol_reg, top_reg, bot_reg;
    logic       lcol_ok_reg, rcol_ok_reg, top_ok_reg, bot_ok_reg;

    // row walker
    logic [7:0] row_reg;
    logic [8:0] cnt_reg;
    logic       down_reg;

    logic res_stat_reg, res_pix_reg;

    logic [MAX_HEIGHT-1:0] row_vld_reg;
    logic                  s1_vld_reg;
    logic [7:0]            s1_row_reg;

    logic out_vld_reg, out_pix_reg, out_stat_reg;

    // setup arithmetic
    logic signed [17:0] px18, py18, sw18, sh18, xe, ye, rc18, bot18;
    logic [8:0] y0, y1;
    logic [7:0] setup_row;
    logic [8:0] setup_cnt;
    logic       setup_down, setup_stat;

    logic [MAX_WIDTH-1:0] ram_rdata, cur_row, mask, new_row;
    logic [RowAw-1:0]     s1_idx;
    logic                 is_draw, wr_en, edge_row;

    assign dim_w = (scr_w_reg > MaxW) ? MaxW : scr_w_reg;
    assign dim_h = ({2'b0, scr_h_reg} > MaxH) ? MaxH : {2'b0, scr_h_reg};

    assign px18  = $signed({{2{px_reg[15]}}, px_reg});
    assign py18  = $signed({{2{py_reg[15]}}, py_reg});
    assign sw18  = $signed({3'b0, sw_reg});
    assign sh18  = $signed({3'b0, sh_reg});
    assign xe    = px18 + sw18;
    assign ye    = py18 + sh18;
    assign rc18  = xe - 18'sd1;
    assign bot18 = ye - 18'sd1;
    assign y0    = clamp_dim(py18, Full);
    assign y1    = clamp_dim(ye, dim_h);

    always_comb begin
        setup_row  = y0[7:0];
        setup_cnt  = '0;
        setup_down = 1'b0;
        setup_stat = 1'b0;
        unique case (mode_reg)
            MODE_FILL: begin
                if (y1 > y0) setup_cnt = y1 - y0;
            end
            MODE_OUTLINE: begin
                if (sw_reg != '0 && y1 > y0) setup_cnt = y1 - y0;
            end
            MODE_CURSOR: begin
                setup_row  = py_reg[7:0];
                setup_cnt  = {1'b0, sh_reg[7:0]};
                setup_down = 1'b1;
            end
            MODE_READ: begin
                setup_row = py_reg[7:0];
                if (in_dim(px18, dim_w) && in_dim(py18, dim_h)) begin
                    setup_cnt = 9'd1;
                end else begin
                    setup_stat = 1'b1;
                end
            end
            default: begin
                setup_cnt = '0;
            end
        endcase
    end

    // row store
    mfde_ram #(
        .WIDTH(MAX_WIDTH),
        .DEPTH(MAX_HEIGHT)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (s1_idx),
        .wdata (new_row),
        .raddr (row_reg[RowAw-1:0]),
        .rdata (ram_rdata)
    );

    assign s1_idx   = s1_row_reg[RowAw-1:0];
    assign cur_row  = row_vld_reg[s1_idx] ? ram_rdata : '0;
    assign edge_row = (top_ok_reg && s1_row_reg == top_reg) ||
                      (bot_ok_reg && s1_row_reg == bot_reg);
    assign is_draw  = (mode_reg == MODE_FILL) || (mode_reg == MODE_OUTLINE) ||
                      (mode_reg == MODE_CURSOR);
    assign wr_en    = s1_vld_reg && is_draw && ({1'b0, s1_row_reg} < dim_h);

    // per-column write mask for the row in the second stage
    always_comb begin
        for (int c = 0; c < MAX_WIDTH; c++) begin : g_col
            logic [8:0] cc;
            logic [7:0] off;
            cc  = 9'(c);
            off = cc[7:0] - px_reg[7:0];
            case (mode_reg)
                MODE_FILL:    mask[c] = (cc >= x0_reg) && (cc < x1_reg);
                MODE_OUTLINE: mask[c] = (lcol_ok_reg && cc == {1'b0, lcol_reg}) ||
                                        (rcol_ok_reg && cc == {1'b0, rcol_reg}) ||
                                        (edge_row && cc >= x0_reg && cc < x1_reg);
                MODE_CURSOR:  mask[c] = (cc < dim_w) && (off < sw_reg[7:0]);
                default:      mask[c] = 1'b0;
            endcase
        end
    end

    assign new_row = (mode_reg == MODE_CURSOR) ? (cur_row ^ mask) : (cur_row | mask);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg   <= 9'd128;
            scr_h_reg   <= 7'd64;
            cnt_reg     <= '0;
            row_vld_reg <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_SCREEN_WIDTH) scr_w_reg <= cfg_wdata;
                if (cfg_index == REG_SCREEN_HEIGHT) scr_h_reg <= cfg_wdata[6:0];
            end
            if (cmd.setup) begin
                cnt_reg <= setup_cnt;
            end else if (cmd.step) begin
                cnt_reg <= cnt_reg - 9'd1;
            end
            if (cmd.setup && mode_reg == MODE_CLEAR) begin
                row_vld_reg <= '0;
            end else if (wr_en) begin
                row_vld_reg[s1_idx] <= 1'b1;
            end
            s1_vld_reg <= cmd.step;
            if (cmd.push) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= mode;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            sw_reg   <= size_w;
            sh_reg   <= size_h;
        end
        if (cmd.setup) begin
            x0_reg       <= clamp_dim(px18, Full);
            x1_reg       <= clamp_dim(xe, dim_w);
            lcol_reg     <= px18[7:0];
            lcol_ok_reg  <= in_dim(px18, dim_w);
            rcol_reg     <= rc18[7:0];
            rcol_ok_reg  <= in_dim(rc18, dim_w);
            top_reg      <= py18[7:0];
            top_ok_reg   <= in_dim(py18, dim_h);
            bot_reg      <= bot18[7:0];
            bot_ok_reg   <= in_dim(bot18, dim_h);
            row_reg      <= setup_row;
            down_reg     <= setup_down;
            res_stat_reg <= setup_stat;
            res_pix_reg  <= 1'b0;
        end else if (cmd.step) begin
            row_reg <= down_reg ? (row_reg - 8'd1) : (row_reg + 8'd1);
        end
        if (cmd.step) begin
            s1_row_reg <= row_reg;
        end
        if (s1_vld_reg && mode_reg == MODE_READ) begin
            res_pix_reg <= cur_row[px_reg[ColAw-1:0]];
        end
        if (cmd.push) begin
            out_pix_reg  <= res_pix_reg;
            out_stat_reg <= res_stat_reg;
        end
    end

    assign stat.walk_done = (cnt_reg == '0);
    assign stat.out_full  = out_vld_reg;

    assign m_valid       = out_vld_reg;
    assign m_pixel_value = out_pix_reg;
    assign m_status      = out_stat_reg;

endmodule
